### rtl/b58_pkg.sv
// ----------------------------------------------------------------------------
// b58_pkg: shared types and constants for the Base58 decoder
// Character classes, digit lookup, phase, status and sequencer types.
// ----------------------------------------------------------------------------
`default_nettype none

package b58_pkg;

    // Radix of the encoding and the width of the carry of one multiply-add step
    localparam int unsigned C_RADIX   = 58;
    localparam int unsigned C_CARRY_W = 6;

    // Saturating character and zero counters
    localparam int unsigned         C_CNT_W   = 7;
    localparam logic [C_CNT_W-1:0]  C_CNT_MAX = '1;

    // Result count limit per string
    localparam int unsigned         C_RES_W   = 7;
    localparam logic [C_RES_W-1:0]  C_MAX_RES = 7'd64;

    // Digit lookup code for a character outside the alphabet
    localparam logic [7:0] C_NO_DIGIT = 8'hFF;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BADCHAR = 2'd1,
        ST_EXTRA   = 2'd2,
        ST_LONG    = 2'd3
    } t_status;

    // Per-string parse phase
    typedef enum logic [2:0] {
        PH_LEAD   = 3'd0,
        PH_ZEROS  = 3'd1,
        PH_DIGITS = 3'd2,
        PH_TRAIL  = 3'd3,
        PH_ERROR  = 3'd4
    } t_phase;

    // Sequencer states
    typedef enum logic [3:0] {
        SQ_IDLE,
        SQ_ADD,
        SQ_DECIDE,
        SQ_SRD,
        SQ_SCHK,
        SQ_ZERO,
        SQ_BRD,
        SQ_BYTE,
        SQ_FINAL,
        SQ_DONE
    } t_seq;

    // Whitespace: tab through carriage return, and space
    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    // Alphabet lookup: 123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz
    function automatic logic [7:0] digit_value(input logic [7:0] c);
        logic [7:0] d;
        d = C_NO_DIGIT;
        if (c >= 8'h31 && c <= 8'h39) begin
            d = c - 8'h31;          // '1'..'9' -> 0..8
        end else if (c >= 8'h41 && c <= 8'h48) begin
            d = c - 8'h38;          // 'A'..'H' -> 9..16
        end else if (c >= 8'h4A && c <= 8'h4E) begin
            d = c - 8'h39;          // 'J'..'N' -> 17..21
        end else if (c >= 8'h50 && c <= 8'h5A) begin
            d = c - 8'h3A;          // 'P'..'Z' -> 22..32
        end else if (c >= 8'h61 && c <= 8'h6B) begin
            d = c - 8'h40;          // 'a'..'k' -> 33..43
        end else if (c >= 8'h6D && c <= 8'h7A) begin
            d = c - 8'h41;          // 'm'..'z' -> 44..57
        end
        return d;
    endfunction

endpackage

`default_nettype wire

### rtl/b58_mac.sv
// ----------------------------------------------------------------------------
// b58_mac: byte buffer memory with the radix-58 multiply-add step
// Little-endian byte store (entry 0 is least significant), registered read,
// and one byte of buffer * 58 + carry per cycle written back in place.
// ----------------------------------------------------------------------------
`default_nettype none

module b58_mac
    import b58_pkg::*;
#(
    parameter int BUF_BYTES = 47
) (
    input  wire                          i_clk,
    input  wire  [$clog2(BUF_BYTES)-1:0] i_rd_addr,
    input  wire                          i_wr_en,
    input  wire  [$clog2(BUF_BYTES)-1:0] i_wr_addr,
    input  wire                          i_in_use,   // entry holds live data
    input  wire  [C_CARRY_W-1:0]         i_carry,
    output logic [7:0]                   o_rd_data,
    output logic [C_CARRY_W-1:0]         o_carry
);

    localparam int SUM_W = 8 + C_CARRY_W;

    logic [7:0]       r_mem [BUF_BYTES];
    logic [7:0]       r_rd;
    logic [7:0]       data_m;
    logic [SUM_W-1:0] sum;

    // Bytes past the fill count read as zero
    assign data_m = i_in_use ? r_rd : 8'h00;
    assign sum    = SUM_W'(i_carry) + SUM_W'(data_m) * SUM_W'(C_RADIX);

    assign o_carry   = sum[SUM_W-1:8];
    assign o_rd_data = r_rd;

    // Buffer memory: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= sum[7:0];
        end
        r_rd <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

### rtl/base58_decoder_core.sv
// ----------------------------------------------------------------------------
// base58_decoder_core: Base58 string decoder
// One character per input item, decoded into a stream of bytes per string.
// ----------------------------------------------------------------------------
// A character that is not a digit, or a leading '1', needs no multiply-add
// step. A digit runs it over the buffer bytes it touches (at most BUF_BYTES):
// the byte buffer sits in a single memory and the multiply-add walks it one
// byte per cycle. After the last character the decoder scans down to the
// top nonzero buffer byte, then sends one byte per leading zero and then
// the buffer bytes from the top down; no new item is taken until the final
// result of the string is in the output register. The buffer needs no
// clearing pass: a fill count marks its live bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module base58_decoder_core
    import b58_pkg::*;
#(
    parameter int MAX_CHARS = 64,
    parameter int BUF_BYTES = 47
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    // input characters
    input  wire        i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  wire  [7:0] i_s_axis_tdata,   // [7:0] char_code
    input  wire        i_s_axis_tlast,   // last_char
    // decoded results
    output logic       o_m_axis_tvalid,
    input  wire        i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic       o_m_axis_tlast,   // last_result
    output logic [2:0] o_m_axis_tuser    // [0] byte_valid, [2:1] status
);

    localparam int IW = $clog2(BUF_BYTES + 1);
    localparam int AW = $clog2(BUF_BYTES);

    // Registers
    t_seq                 r_seq, n_seq;
    t_phase               r_phase, n_phase;
    t_status              r_err, n_err;
    logic [C_CNT_W-1:0]   r_char_cnt, n_char_cnt;
    logic [C_CNT_W-1:0]   r_zero_cnt, n_zero_cnt;
    logic [IW-1:0]        r_used, n_used;
    logic [IW-1:0]        r_idx, n_idx;
    logic [C_CARRY_W-1:0] r_carry, n_carry;
    logic [C_RES_W-1:0]   r_n, n_n;
    logic                 r_last, n_last;
    logic                 r_has, n_has;
    logic                 r_ovld, n_ovld;
    logic [7:0]           r_obyte, n_obyte;
    logic                 r_obv, n_obv;
    logic                 r_olast, n_olast;
    t_status              r_ostat, n_ostat;

    // Character decode
    logic [7:0]           cd;
    logic                 sp;
    t_phase               tk_phase;
    t_status              tk_err;
    logic [C_CNT_W-1:0]   tk_cnt;
    logic [C_CNT_W-1:0]   tk_zero;
    logic                 tk_add;

    // Control and datapath
    logic                 s_ready;
    logic                 s_acc;
    logic                 out_free;
    logic                 in_use;
    logic                 add_go;
    logic [IW-1:0]        idx_inc;
    logic                 res_full;
    logic                 zero_more;
    logic                 zero_last;
    logic                 byte_last;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [7:0]           rd_data;
    logic [C_CARRY_W-1:0] mac_carry;
    logic                 emit;
    logic [7:0]           e_byte;
    logic                 e_bv;
    logic                 e_last;
    t_status              e_stat;

    assign cd        = digit_value(i_s_axis_tdata);
    assign sp        = is_space(i_s_axis_tdata);
    assign s_acc     = i_s_axis_tvalid && s_ready;
    assign out_free  = !r_ovld || i_m_axis_tready;
    assign in_use    = r_idx < r_used;
    assign add_go    = ((r_carry != '0) || in_use) && (r_idx < IW'(BUF_BYTES));
    assign idx_inc   = r_idx + IW'(1);
    assign res_full  = r_n == C_MAX_RES;
    assign zero_more = (r_zero_cnt != '0) && !res_full;
    assign zero_last = (r_n == C_MAX_RES - C_RES_W'(1))
                    || ((r_zero_cnt == C_CNT_W'(1)) && !r_has);
    assign byte_last = (r_idx == '0) || (r_n == C_MAX_RES - C_RES_W'(1));

    // Buffer memory and multiply-add
    b58_mac #(
        .BUF_BYTES (BUF_BYTES)
    ) u_mac (
        .i_clk     (i_clk),
        .i_rd_addr (rd_addr),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_idx[AW-1:0]),
        .i_in_use  (in_use),
        .i_carry   (r_carry),
        .o_rd_data (rd_data),
        .o_carry   (mac_carry)
    );

    // Per-character parse step on the current string state
    always_comb begin
        tk_phase = r_phase;
        tk_err   = r_err;
        tk_cnt   = r_char_cnt;
        tk_zero  = r_zero_cnt;
        tk_add   = 1'b0;
        if (r_phase != PH_ERROR) begin
            tk_cnt = (r_char_cnt == C_CNT_MAX) ? r_char_cnt : r_char_cnt + C_CNT_W'(1);
            if (tk_cnt > C_CNT_W'(MAX_CHARS)) begin
                tk_phase = PH_ERROR;
                tk_err   = ST_LONG;
            end else begin
                case (r_phase)
                    PH_LEAD, PH_ZEROS: begin
                        if (sp) begin
                            if (r_phase == PH_ZEROS) begin
                                tk_phase = PH_TRAIL;
                            end
                        end else if (cd == 8'h00) begin
                            if (r_zero_cnt != C_CNT_MAX) begin
                                tk_zero = r_zero_cnt + C_CNT_W'(1);
                            end
                            tk_phase = PH_ZEROS;
                        end else if (cd == C_NO_DIGIT) begin
                            tk_phase = PH_ERROR;
                            tk_err   = ST_BADCHAR;
                        end else begin
                            tk_add   = 1'b1;
                            tk_phase = PH_DIGITS;
                        end
                    end
                    PH_DIGITS: begin
                        if (sp) begin
                            tk_phase = PH_TRAIL;
                        end else if (cd == C_NO_DIGIT) begin
                            tk_phase = PH_ERROR;
                            tk_err   = ST_BADCHAR;
                        end else begin
                            tk_add = 1'b1;
                        end
                    end
                    default: begin
                        if (!sp) begin
                            tk_phase = PH_ERROR;
                            tk_err   = ST_EXTRA;
                        end
                    end
                endcase
            end
        end
    end

    // Sequencer next state
    always_comb begin
        n_seq = r_seq;
        case (r_seq)
            SQ_IDLE: begin
                if (s_acc) begin
                    if (tk_add) begin
                        n_seq = SQ_ADD;
                    end else if (i_s_axis_tlast) begin
                        n_seq = SQ_DECIDE;
                    end
                end
            end
            SQ_ADD: begin
                if (!add_go) begin
                    n_seq = r_last ? SQ_DECIDE : SQ_IDLE;
                end
            end
            SQ_DECIDE: begin
                if (r_phase == PH_ERROR) begin
                    n_seq = SQ_FINAL;
                end else if (r_used == '0) begin
                    n_seq = SQ_ZERO;
                end else begin
                    n_seq = SQ_SRD;
                end
            end
            SQ_SRD: begin
                n_seq = SQ_SCHK;
            end
            SQ_SCHK: begin
                n_seq = ((rd_data != 8'h00) || (r_idx == '0)) ? SQ_ZERO : SQ_SRD;
            end
            SQ_ZERO: begin
                if (!zero_more) begin
                    if (r_has && !res_full) begin
                        n_seq = SQ_BRD;
                    end else if (r_n == '0) begin
                        n_seq = SQ_FINAL;
                    end else begin
                        n_seq = SQ_DONE;
                    end
                end
            end
            SQ_BRD: begin
                n_seq = SQ_BYTE;
            end
            SQ_BYTE: begin
                if (out_free) begin
                    n_seq = byte_last ? SQ_DONE : SQ_BRD;
                end
            end
            SQ_FINAL: begin
                if (out_free) begin
                    n_seq = SQ_DONE;
                end
            end
            SQ_DONE: begin
                n_seq = SQ_IDLE;
            end
            default: begin
                n_seq = SQ_IDLE;
            end
        endcase
    end

    // Sequencer outputs: handshake, memory port, result to load
    always_comb begin
        s_ready = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        emit    = 1'b0;
        e_byte  = 8'h00;
        e_bv    = 1'b0;
        e_last  = 1'b0;
        e_stat  = ST_OK;
        case (r_seq)
            SQ_IDLE: begin
                s_ready = 1'b1;
            end
            SQ_ADD: begin
                wr_en = add_go;
                if (idx_inc < IW'(BUF_BYTES)) begin
                    rd_addr = idx_inc[AW-1:0];
                end
            end
            SQ_SRD, SQ_SCHK, SQ_BRD: begin
                rd_addr = r_idx[AW-1:0];
            end
            SQ_BYTE: begin
                rd_addr = r_idx[AW-1:0];
                emit    = out_free;
                e_byte  = rd_data;
                e_bv    = 1'b1;
                e_last  = byte_last;
            end
            SQ_ZERO: begin
                emit   = zero_more && out_free;
                e_bv   = 1'b1;
                e_last = zero_last;
            end
            SQ_FINAL: begin
                emit   = out_free;
                e_last = 1'b1;
                e_stat = r_err;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb begin
        n_phase    = r_phase;
        n_err      = r_err;
        n_char_cnt = r_char_cnt;
        n_zero_cnt = r_zero_cnt;
        n_used     = r_used;
        n_idx      = r_idx;
        n_carry    = r_carry;
        n_n        = r_n;
        n_last     = r_last;
        n_has      = r_has;
        n_ovld     = r_ovld;
        n_obyte    = r_obyte;
        n_obv      = r_obv;
        n_olast    = r_olast;
        n_ostat    = r_ostat;

        case (r_seq)
            SQ_IDLE: begin
                if (s_acc) begin
                    n_phase    = tk_phase;
                    n_err      = tk_err;
                    n_char_cnt = tk_cnt;
                    n_zero_cnt = tk_zero;
                    n_last     = i_s_axis_tlast;
                    n_idx      = '0;
                    n_carry    = cd[C_CARRY_W-1:0];
                end
            end
            SQ_ADD: begin
                if (add_go) begin
                    n_idx   = idx_inc;
                    n_carry = mac_carry;
                end else begin
                    n_used = r_idx;
                end
            end
            SQ_DECIDE: begin
                n_has = 1'b0;
                n_idx = r_used - IW'(1);
            end
            SQ_SCHK: begin
                if (rd_data != 8'h00) begin
                    n_has = 1'b1;
                end else if (r_idx != '0) begin
                    n_idx = r_idx - IW'(1);
                end
            end
            SQ_ZERO: begin
                if (emit) begin
                    n_zero_cnt = r_zero_cnt - C_CNT_W'(1);
                    n_n        = r_n + C_RES_W'(1);
                end
            end
            SQ_BYTE: begin
                if (emit) begin
                    n_n = r_n + C_RES_W'(1);
                    if (!byte_last) begin
                        n_idx = r_idx - IW'(1);
                    end
                end
            end
            SQ_DONE: begin
                // Back to the start-of-string state
                n_phase    = PH_LEAD;
                n_err      = ST_OK;
                n_char_cnt = '0;
                n_zero_cnt = '0;
                n_used     = '0;
                n_n        = '0;
                n_last     = 1'b0;
                n_has      = 1'b0;
            end
            default: begin
                n_phase = r_phase;
            end
        endcase

        // Output register
        if (emit) begin
            n_ovld  = 1'b1;
            n_obyte = e_byte;
            n_obv   = e_bv;
            n_olast = e_last;
            n_ostat = e_stat;
        end else if (i_m_axis_tready) begin
            n_ovld = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq      <= SQ_IDLE;
            r_phase    <= PH_LEAD;
            r_err      <= ST_OK;
            r_char_cnt <= '0;
            r_zero_cnt <= '0;
            r_used     <= '0;
            r_n        <= '0;
            r_last     <= 1'b0;
            r_has      <= 1'b0;
            r_ovld     <= 1'b0;
        end else begin
            r_seq      <= n_seq;
            r_phase    <= n_phase;
            r_err      <= n_err;
            r_char_cnt <= n_char_cnt;
            r_zero_cnt <= n_zero_cnt;
            r_used     <= n_used;
            r_n        <= n_n;
            r_last     <= n_last;
            r_has      <= n_has;
            r_ovld     <= n_ovld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_carry <= n_carry;
        r_obyte <= n_obyte;
        r_obv   <= n_obv;
        r_olast <= n_olast;
        r_ostat <= n_ostat;
    end

    assign o_s_axis_tready = s_ready;
    assign o_m_axis_tvalid = r_ovld;
    assign o_m_axis_tdata  = r_obyte;
    assign o_m_axis_tlast  = r_olast;
    assign o_m_axis_tuser  = {r_ostat, r_obv};

endmodule

`default_nettype wire

### rtl/b58_chk.sv
// ----------------------------------------------------------------------------
// b58_chk: port-level checks for the Base58 decoder
// Watches the stream ports of the decoder core over time.
// ----------------------------------------------------------------------------
`default_nettype none

module b58_chk (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_s_axis_tvalid,
    input wire       o_s_axis_tready,
    input wire       i_s_axis_tlast,
    input wire       o_m_axis_tvalid,
    input wire       i_m_axis_tready,
    input wire [7:0] o_m_axis_tdata,
    input wire       o_m_axis_tlast,
    input wire [2:0] o_m_axis_tuser
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)
            && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // An empty or error result closes its string and carries no byte
    a_nobyte_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |->
            o_m_axis_tlast && (o_m_axis_tdata == 8'h00))
        else $error("result without byte is not a clean final result");

    // An error status never comes with a byte
    a_err_nobyte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser[2:1] != 2'b00) |-> !o_m_axis_tuser[0])
        else $error("error result flagged as a byte");

    // The final character of a string holds off the next one
    a_last_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast |=> !o_s_axis_tready)
        else $error("input taken right after a final character");

    // Reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind base58_decoder_core b58_chk u_b58_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tlast  (i_s_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire
